FILE: hdl/fxalu_pkg.sv
// shared types, command codes and constants for the q24.8 fixed-point alu
package fxalu_pkg;

	localparam int FRACTION_BITS_DEF = 8;

	localparam logic signed [31:0] RES_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] RES_MIN = 32'sh8000_0000;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0,
		CMD_SUB = 4'd1,
		CMD_MUL = 4'd2,
		CMD_DIV = 4'd3,
		CMD_GT  = 4'd4,
		CMD_GE  = 4'd5,
		CMD_LT  = 4'd6,
		CMD_LE  = 4'd7,
		CMD_EQ  = 4'd8,
		CMD_NE  = 4'd9,
		CMD_MIN = 4'd10,
		CMD_MAX = 4'd11,
		CMD_INC = 4'd12,
		CMD_DEC = 4'd13
	} cmd_e;

	typedef struct packed {
		logic [3:0]         command;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               compare_true;
		logic               divide_by_zero;
	} rsp_t;

	// per-beat data that rides alongside the divider stages
	typedef struct packed {
		logic [3:0]         command;
		logic               quo_neg;
		logic               div_zero;
		logic               a_neg;
		logic signed [31:0] result_value;
		logic               compare_true;
	} side_t;

endpackage

FILE: hdl/fixed_point_q24_8_alu_unit.sv
// top level of the pipelined q24.8 fixed-point alu
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+---------------------------
//  request | req_valid | req_ready | req_data (command, operands)
//  result  | rsp_valid | rsp_ready | rsp_data (value, flags)
//
// one beat accepted per cycle while the skid entry is empty; every command takes the
// same path, so results come back in order, with the path length set by the
// one-bit-per-stage divider.
// arst_n clears all valid bits; data registers are not reset.
// an output register plus a skid entry decouple the sides; the pipeline holds
// only while the skid entry is full, and req_ready is a register output.
module fixed_point_q24_8_alu_unit #(
	parameter int FRACTION_BITS = fxalu_pkg::FRACTION_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  fxalu_pkg::req_t req_data,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output fxalu_pkg::rsp_t rsp_data
);
	import fxalu_pkg::*;

	localparam int NW    = 32 + FRACTION_BITS;
	localparam int QW    = NW + 1;
	localparam int DEPTH = NW + 2;
	localparam logic [QW-1:0] Q_HALF = QW'(64'h8000_0000);

	logic                en;
	logic signed [31:0]  a0, b0;
	logic signed [31:0]  res0;
	logic                cmp0;
	logic [31:0]         mag_a0, mag_b0;

	logic                vld_s1;
	side_t               side_s1;
	logic signed [31:0]  a_s1, b_s1;
	logic [31:0]         mag_a_s1, mag_b_s1;
	logic signed [63:0]  prod_s1;

	logic                vld_sx  [2:DEPTH];
	side_t               side_sx [2:DEPTH];
	side_t               side_mul;

	logic [QW-1:0]       q_div;
	logic signed [31:0]  div_res;
	rsp_t                fin;

	logic                out_vld_q, skid_vld_q;
	rsp_t                out_q, skid_q;
	logic                push, out_fire;

	assign en        = !skid_vld_q;
	assign req_ready = en;

	// stage 0: simple ops and operand magnitudes
	assign a0     = req_data.operand_a;
	assign b0     = req_data.operand_b;
	assign mag_a0 = a0[31] ? (~a0 + 32'd1) : a0;
	assign mag_b0 = b0[31] ? (~b0 + 32'd1) : b0;

	always_comb begin
		res0 = '0;
		cmp0 = 1'b0;
		unique case (cmd_e'(req_data.command))
			CMD_ADD: res0 = a0 + b0;
			CMD_SUB: res0 = a0 - b0;
			CMD_MUL: res0 = '0;
			CMD_DIV: res0 = '0;
			CMD_GT:  cmp0 = a0 > b0;
			CMD_GE:  cmp0 = a0 >= b0;
			CMD_LT:  cmp0 = a0 < b0;
			CMD_LE:  cmp0 = a0 <= b0;
			CMD_EQ:  cmp0 = a0 == b0;
			CMD_NE:  cmp0 = a0 != b0;
			CMD_MIN: res0 = (a0 < b0) ? a0 : b0;
			CMD_MAX: res0 = (a0 > b0) ? a0 : b0;
			CMD_INC: res0 = a0 + 32'sd1;
			CMD_DEC: res0 = a0 - 32'sd1;
			default: res0 = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.command      <= req_data.command;
			side_s1.quo_neg      <= a0[31] ^ b0[31];
			side_s1.div_zero     <= b0 == 32'sd0;
			side_s1.a_neg        <= a0[31];
			side_s1.result_value <= res0;
			side_s1.compare_true <= cmp0;
			a_s1                 <= a0;
			b_s1                 <= b0;
			mag_a_s1             <= mag_a0;
			mag_b_s1             <= mag_b0;
		end
	end

	// stage 1 -> 2: full signed product, keep bits above the fraction
	assign prod_s1 = a_s1 * b_s1;

	always_comb begin
		side_mul = side_s1;
		if (cmd_e'(side_s1.command) == CMD_MUL) begin
			side_mul.result_value = prod_s1[FRACTION_BITS+31:FRACTION_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 2; k <= DEPTH; k++) begin
				vld_sx[k] <= 1'b0;
			end
		end else if (en) begin
			vld_sx[2] <= vld_s1;
			for (int k = 3; k <= DEPTH; k++) begin
				vld_sx[k] <= vld_sx[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sx[2] <= side_mul;
			for (int k = 3; k <= DEPTH; k++) begin
				side_sx[k] <= side_sx[k-1];
			end
		end
	end

	fxalu_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.en       (en),
		.dividend (mag_a_s1),
		.divisor  (mag_b_s1),
		.quotient (q_div)
	);

	// last stage: sign and saturate the quotient, pick the result
	always_comb begin
		if (side_sx[DEPTH].div_zero) begin
			div_res = side_sx[DEPTH].a_neg ? RES_MIN : RES_MAX;
		end else if (side_sx[DEPTH].quo_neg) begin
			div_res = (q_div > Q_HALF) ? RES_MIN : (~q_div[31:0] + 32'd1);
		end else begin
			div_res = (q_div >= Q_HALF) ? RES_MAX : q_div[31:0];
		end
	end

	always_comb begin
		if (cmd_e'(side_sx[DEPTH].command) == CMD_DIV) begin
			fin.result_value   = div_res;
			fin.compare_true   = 1'b0;
			fin.divide_by_zero = side_sx[DEPTH].div_zero;
		end else begin
			fin.result_value   = side_sx[DEPTH].result_value;
			fin.compare_true   = side_sx[DEPTH].compare_true;
			fin.divide_by_zero = 1'b0;
		end
	end

	// output register with one skid entry
	assign push     = en && vld_sx[DEPTH];
	assign out_fire = out_vld_q && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_fire) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !out_fire) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !out_fire) begin
				skid_q <= fin;
			end else begin
				out_q <= fin;
			end
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp_data  = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry full while output register empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !rsp_ready))
		else $error("skid entry filled without an output stall");

	a_dz_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.divide_by_zero) |->
			(out_q.result_value == RES_MAX || out_q.result_value == RES_MIN))
		else $error("divide by zero without a saturated result");

	a_cmp_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.compare_true) |->
			(out_q.result_value == 32'sd0 && !out_q.divide_by_zero))
		else $error("comparison beat carries a value or a divide flag");

endmodule

FILE: hdl/fxalu_div.sv
// pipelined restoring divider, one quotient bit per stage, rounds half up on magnitudes
module fxalu_div #(
	parameter int FRACTION_BITS = fxalu_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [31:0]                   dividend,
	input  logic [31:0]                   divisor,
	output logic [32+FRACTION_BITS:0]     quotient
);
	import fxalu_pkg::*;

	localparam int NW = 32 + FRACTION_BITS;
	localparam int QW = NW + 1;

	logic [31:0]    rem_s [NW];
	logic [NW-1:0]  quo_s [NW];
	logic [NW-1:0]  num_s [NW-1];
	logic [31:0]    den_s [NW];
	logic [NW-1:0]  num_first;
	logic           round_up;

	assign num_first = NW'(dividend) << FRACTION_BITS;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [31:0]   rem_in;
		logic [31:0]   den_in;
		logic [NW-1:0] quo_in;
		logic [NW-1:0] num_in;
		logic [32:0]   trial;
		logic [32:0]   diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = '0;
			assign num_in = num_first;
			assign den_in = divisor;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign quo_in = quo_s[i-1];
			assign num_in = num_s[i-1];
			assign den_in = den_s[i-1];
		end

		assign trial = {rem_in, num_in[NW-1]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = trial >= {1'b0, den_in};

		// while the divisor is nonzero, the partial remainder stays below it, so 32 bits hold it
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[31:0] : trial[31:0];
				quo_s[i] <= {quo_in[NW-2:0], ge};
				den_s[i] <= den_in;
			end
		end

		// the last stage has no numerator bits left to pass on
		if (i < NW - 1) begin : g_shift
			always_ff @(posedge clk) begin
				if (en) begin
					num_s[i] <= num_in << 1;
				end
			end
		end
	end

	assign round_up = {rem_s[NW-1], 1'b0} >= {1'b0, den_s[NW-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			quotient <= QW'(quo_s[NW-1]) + QW'(round_up);
		end
	end

endmodule
